FILE: rtl/brem_pkg.sv
package brem_pkg;

  localparam int FRAC_BITS = 16;

  localparam int H_W   = 32;              // positive cell width/height magnitude
  localparam int Q_W   = H_W + FRAC_BITS; // hy/hx and hx/hy ratios
  localparam int D_W   = Q_W + 3;         // signed doubled stiffness entry
  localparam int B_W   = Q_W + 2;         // multiplier operand magnitude
  localparam int A_W   = 2 * H_W;         // multiplicand (area or |coef|)
  localparam int P_W   = A_W + B_W;       // full product
  localparam int ACC_W = 36;              // weighted f sums, 9 * 2^31 fits
  localparam int QD_W  = 37;              // unsaturated dividend, below 2^31 * 36 + 36
  localparam int CNT_W = $clog2(B_W);

  // reciprocals ceil(2^RCP_SH / dv); exact quotient for any dividend below 2^QD_W
  localparam int RCP_SH  = 43;
  localparam int RCP_POS = RCP_SH + B_W - QD_W; // quotient lsb after QD_W serial steps
  localparam logic [A_W-1:0] RCP_STIFF = A_W'(64'd1466015503702);
  localparam logic [A_W-1:0] RCP_MASS  = A_W'(64'd244335917284);

  // saturation thresholds on the shifted product: 2^31 * dv, (2^31 + 1) * dv
  localparam logic [P_W-1:0] THR_STIFF_POS = P_W'(64'd12884901888);
  localparam logic [P_W-1:0] THR_STIFF_NEG = P_W'(64'd12884901894);
  localparam logic [P_W-1:0] THR_MASS_POS  = P_W'(64'd77309411328);
  localparam logic [P_W-1:0] THR_MASS_NEG  = P_W'(64'd77309411364);

  localparam logic [1:0] MODE_STIFF = 2'd0;
  localparam logic [1:0] MODE_MASS  = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] x_left;
    logic signed [31:0] x_right;
    logic signed [31:0] y_bottom;
    logic signed [31:0] y_top;
    logic signed [31:0] coef;
    logic signed [31:0] f_vertex0;
    logic signed [31:0] f_vertex1;
    logic signed [31:0] f_vertex2;
    logic signed [31:0] f_vertex3;
  } in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] entry0;
    logic signed [31:0] entry1;
    logic signed [31:0] entry2;
    logic signed [31:0] entry3;
    logic               saturated;
    logic               size_error;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic                   bad;
    logic [H_W-1:0]         hx;
    logic [H_W-1:0]         hy;
    logic [31:0]            coef;
    logic [3:0][ACC_W-1:0]  acc;
  } job_t;

  // weights {4,2,2,1} as shift amounts, picked by i xor j
  function automatic logic [1:0] wshift(input logic [1:0] idx);
    logic [1:0] s;
    case (idx)
      2'd0:    s = 2'd2;
      2'd3:    s = 2'd0;
      default: s = 2'd1;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/brem_front.sv
module brem_front (
  input  logic               in_valid,
  input  brem_pkg::in_t      in_data,
  output logic               in_ready,
  input  logic               q_full,
  output logic               q_push,
  output brem_pkg::job_t     q_data
);

  logic signed [32:0] hx_w;
  logic signed [32:0] hy_w;
  logic signed [31:0] f_w [4];
  logic [3:0][brem_pkg::ACC_W-1:0] acc_w;

  assign hx_w = {in_data.x_right[31], in_data.x_right} - {in_data.x_left[31], in_data.x_left};
  assign hy_w = {in_data.y_top[31], in_data.y_top} - {in_data.y_bottom[31], in_data.y_bottom};

  assign f_w[0] = in_data.f_vertex0;
  assign f_w[1] = in_data.f_vertex1;
  assign f_w[2] = in_data.f_vertex2;
  assign f_w[3] = in_data.f_vertex3;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc_w[j] = '0;
      for (int k = 0; k < 4; k++) begin
        acc_w[j] = acc_w[j] + (brem_pkg::ACC_W'(f_w[k]) << brem_pkg::wshift(2'(j) ^ 2'(k)));
      end
    end
  end

  assign in_ready = !q_full;
  // mode 3 beats are taken and dropped
  assign q_push   = in_valid && !q_full && (in_data.mode != brem_pkg::MODE_NONE);

  always_comb begin
    q_data      = '0;
    q_data.mode = in_data.mode;
    q_data.bad  = hx_w[32] || (hx_w == '0) || hy_w[32] || (hy_w == '0);
    q_data.hx   = hx_w[brem_pkg::H_W-1:0];
    q_data.hy   = hy_w[brem_pkg::H_W-1:0];
    q_data.coef = in_data.coef;
    q_data.acc  = acc_w;
  end

endmodule

FILE: rtl/brem_fifo.sv
module brem_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  brem_pkg::job_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output brem_pkg::job_t  head
);

  brem_pkg::job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/brem_div.sv
module brem_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [brem_pkg::Q_W-1:0]  num,
  input  logic [brem_pkg::H_W-1:0]  den,
  output logic                      busy,
  output logic [brem_pkg::Q_W-1:0]  quo
);

  localparam int DC_W = $clog2(brem_pkg::Q_W);

  logic [brem_pkg::Q_W-1:0] num_r;
  logic [brem_pkg::H_W-1:0] rem_r, den_r;
  logic [DC_W-1:0]          cnt_r;
  logic                     busy_r;
  logic [brem_pkg::H_W:0]   t, diff;
  logic                     ge;

  assign t    = {rem_r, num_r[brem_pkg::Q_W-1]};
  assign diff = t - {1'b0, den_r};
  assign ge   = (t >= {1'b0, den_r});
  assign busy = busy_r;
  assign quo  = num_r;

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[brem_pkg::Q_W-2:0], ge};
      rem_r <= ge ? diff[brem_pkg::H_W-1:0] : t[brem_pkg::H_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DC_W'(brem_pkg::Q_W - 1)) busy_r <= 1'b0;
    end
  end

endmodule

FILE: rtl/brem_back.sv
module brem_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  brem_pkg::job_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output brem_pkg::out_t  out_data
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RDIV = 7'b0000010,
    ST_LOAD = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_CHK  = 7'b0010000,
    ST_QDIV = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t                         state_r;
  brem_pkg::job_t                 job_r;
  logic [brem_pkg::A_W-1:0]       area_r, a_r;
  logic [3:0][brem_pkg::D_W-1:0]  d_r;
  logic [brem_pkg::P_W-1:0]       p_r;
  logic [brem_pkg::CNT_W-1:0]     cnt_r;
  logic [1:0]                     k_r, row_r;
  logic                           neg_r;
  logic [3:0][31:0]               e_r;
  logic [3:0]                     es_r;
  brem_pkg::out_t                 out_r;
  logic                           out_valid_r;

  logic                           div_start, r_busy, s_busy;
  logic [brem_pkg::Q_W-1:0]       r_quo, s_quo;
  logic [brem_pkg::A_W-1:0]       area_w;

  brem_div u_div_r (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({q_head.hy, {brem_pkg::FRAC_BITS{1'b0}}}),
    .den   (q_head.hx),
    .busy  (r_busy),
    .quo   (r_quo)
  );

  brem_div u_div_s (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({q_head.hx, {brem_pkg::FRAC_BITS{1'b0}}}),
    .den   (q_head.hy),
    .busy  (s_busy),
    .quo   (s_quo)
  );

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign div_start = q_pop && !q_head.bad && (q_head.mode == brem_pkg::MODE_STIFF);
  assign area_w    = q_head.hx * q_head.hy;

  // doubled stiffness entries from the two ratios
  logic [brem_pkg::D_W-1:0] rr, ss;
  assign rr = brem_pkg::D_W'(r_quo);
  assign ss = brem_pkg::D_W'(s_quo);

  // operands for entry k
  logic [31:0]                coef_mag;
  logic [brem_pkg::D_W-1:0]   d_k, d_mag;
  logic [brem_pkg::ACC_W-1:0] acc_k, acc_mag;
  logic [brem_pkg::A_W-1:0]   a_w;
  logic [brem_pkg::B_W-1:0]   b_w;
  logic                       neg_w;

  assign coef_mag = job_r.coef[31] ? (32'd0 - job_r.coef) : job_r.coef;
  assign d_k      = d_r[k_r];
  assign d_mag    = d_k[brem_pkg::D_W-1] ? ('0 - d_k) : d_k;
  assign acc_k    = job_r.acc[k_r];
  assign acc_mag  = acc_k[brem_pkg::ACC_W-1] ? ('0 - acc_k) : acc_k;

  always_comb begin
    case (job_r.mode)
      brem_pkg::MODE_STIFF: begin
        a_w   = brem_pkg::A_W'(coef_mag);
        b_w   = d_mag[brem_pkg::B_W-1:0];
        neg_w = job_r.coef[31] ^ d_k[brem_pkg::D_W-1];
      end
      brem_pkg::MODE_MASS: begin
        a_w   = area_r;
        b_w   = brem_pkg::B_W'(coef_mag) << brem_pkg::wshift(k_r);
        neg_w = job_r.coef[31];
      end
      default: begin
        a_w   = area_r;
        b_w   = brem_pkg::B_W'(acc_mag);
        neg_w = acc_k[brem_pkg::ACC_W-1];
      end
    endcase
  end

  // shift-add multiply step, shared by the product and the reciprocal pass
  logic [brem_pkg::A_W:0]   mul_t;
  logic [brem_pkg::P_W-1:0] p_step;
  assign mul_t  = {1'b0, p_r[brem_pkg::P_W-1:brem_pkg::B_W]}
                + (p_r[0] ? {1'b0, a_r} : '0);
  assign p_step = {mul_t, p_r[brem_pkg::B_W-1:1]};

  // saturation check on the shifted product
  logic [brem_pkg::P_W-1:0]  ps_w, thr_w;
  logic [brem_pkg::A_W-1:0]  rcp_w;
  logic                      stiff;
  assign stiff = (job_r.mode == brem_pkg::MODE_STIFF);
  assign ps_w  = stiff ? (p_r >> brem_pkg::FRAC_BITS) : (p_r >> (2 * brem_pkg::FRAC_BITS));
  assign rcp_w = stiff ? brem_pkg::RCP_STIFF : brem_pkg::RCP_MASS;
  assign thr_w = stiff ? (neg_r ? brem_pkg::THR_STIFF_NEG : brem_pkg::THR_STIFF_POS)
                       : (neg_r ? brem_pkg::THR_MASS_NEG  : brem_pkg::THR_MASS_POS);

  // divide by 6 or 36 as a multiply by the scaled reciprocal
  logic [31:0] q_res;
  assign q_res = p_step[brem_pkg::RCP_POS+31:brem_pkg::RCP_POS];

  // row assembly
  brem_pkg::out_t row_w;
  logic           is_load;
  assign is_load = (job_r.mode == brem_pkg::MODE_LOAD);
  always_comb begin
    row_w            = '0;
    row_w.row_index  = row_r;
    row_w.entry0     = is_load ? e_r[0] : e_r[row_r ^ 2'd0];
    row_w.entry1     = is_load ? e_r[1] : e_r[row_r ^ 2'd1];
    row_w.entry2     = is_load ? e_r[2] : e_r[row_r ^ 2'd2];
    row_w.entry3     = is_load ? e_r[3] : e_r[row_r ^ 2'd3];
    row_w.saturated  = |es_r;
    row_w.size_error = job_r.bad;
    row_w.last       = is_load || (row_r == 2'd3);
  end

  logic emit_go;
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          job_r  <= q_head;
          area_r <= area_w;
          k_r    <= 2'd0;
          row_r  <= 2'd0;
          e_r    <= '0;
          es_r   <= '0;
        end
      end
      ST_RDIV: begin
        d_r[0] <= (rr << 1) + (ss << 1);
        d_r[1] <= ss - (rr << 1);
        d_r[2] <= rr - (ss << 1);
        d_r[3] <= '0 - (rr + ss);
      end
      ST_LOAD: begin
        a_r   <= a_w;
        p_r   <= {{brem_pkg::A_W{1'b0}}, b_w};
        neg_r <= neg_w;
        cnt_r <= '0;
      end
      ST_MUL: begin
        p_r   <= p_step;
        cnt_r <= cnt_r + 1'b1;
      end
      ST_CHK: begin
        if (ps_w >= thr_w) begin
          e_r[k_r]  <= neg_r ? 32'h8000_0000 : 32'h7fff_ffff;
          es_r[k_r] <= 1'b1;
          k_r       <= k_r + 2'd1;
        end else begin
          a_r   <= rcp_w;
          p_r   <= {{brem_pkg::A_W{1'b0}}, brem_pkg::B_W'(ps_w[brem_pkg::QD_W-1:0])};
          cnt_r <= '0;
        end
      end
      ST_QDIV: begin
        p_r   <= p_step;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == brem_pkg::CNT_W'(brem_pkg::QD_W - 1)) begin
          e_r[k_r] <= neg_r ? (32'd0 - q_res) : q_res;
          k_r      <= k_r + 2'd1;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_r <= row_w;
          row_r <= row_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_head.bad)                              state_r <= ST_EMIT;
            else if (q_head.mode == brem_pkg::MODE_STIFF) state_r <= ST_RDIV;
            else                                         state_r <= ST_LOAD;
          end
        end
        ST_RDIV: begin
          if (!r_busy && !s_busy) state_r <= ST_LOAD;
        end
        ST_LOAD: state_r <= ST_MUL;
        ST_MUL: begin
          if (cnt_r == brem_pkg::CNT_W'(brem_pkg::B_W - 1)) state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (ps_w >= thr_w) state_r <= (k_r == 2'd3) ? ST_EMIT : ST_LOAD;
          else               state_r <= ST_QDIV;
        end
        ST_QDIV: begin
          if (cnt_r == brem_pkg::CNT_W'(brem_pkg::QD_W - 1)) begin
            state_r <= (k_r == 2'd3) ? ST_EMIT : ST_LOAD;
          end
        end
        ST_EMIT: begin
          if (emit_go && row_w.last) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/bilinear_rectangle_element_matrices_unit.sv
// Q1 rectangle element matrices in signed Q16.16. A cell beat enters the front, which forms
// hx, hy, the size check and the weighted load sums and drops mode 3; a two-deep queue feeds
// the back end, which works on one cell at a time. The back end computes four entries, each
// with a bit-serial multiply over its B_W-bit operand, a saturation check and, if not
// clipped, a serial multiply by the reciprocal of 6 or 36; stiffness adds a divide for
// hy/hx and hx/hy up front. Cells with a size error skip the arithmetic. Rows then go out
// one beat per cycle while out_ready is high, four rows for a matrix, one for the load
// vector, through an output register that the next cell does not wait on.
module bilinear_rectangle_element_matrices_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  brem_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output brem_pkg::out_t  out_data
);

  logic           q_full, q_push, q_pop, q_empty;
  brem_pkg::job_t q_wdata, q_head;

  brem_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  brem_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  brem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/brem_checker.sv
module brem_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input brem_pkg::out_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.size_error |-> !out_data.saturated &&
      out_data.entry0 == 0 && out_data.entry1 == 0 &&
      out_data.entry2 == 0 && out_data.entry3 == 0)
    else $error("size error beat with nonzero entries");

  a_row3_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_index == 2'd3 |-> out_data.last)
    else $error("row 3 not marked last");

  a_next_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last ##1 out_valid |->
      out_data.row_index == $past(out_data.row_index) + 2'd1)
    else $error("row sequence broken");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bilinear_rectangle_element_matrices_unit brem_checker u_brem_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
